// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: ante |-> cons");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: ante |=> cons");

`endif

// File: rtl/core/psc_pkg.sv
// ---------------------------------------------------------------------------
// psc_pkg
// Types and constants for the point sequence store with circle scan.
// ---------------------------------------------------------------------------
package psc_pkg;

   localparam int CNT_W  = 6;   // fill count / position width
   localparam int SLOT_W = 5;   // request slot width
   localparam int CSR_W  = 16;  // widest config register
   localparam int CIDX_W = 2;   // config register index width
   localparam int RAD_W  = 15;  // radius width
   localparam int CMD_W  = 3;

   // command codes
   localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_MODIFY = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd4;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SCAN   = 3'd6;

   // config register indexes
   localparam logic [CIDX_W-1:0] CSR_CENTER_X = 2'd0;
   localparam logic [CIDX_W-1:0] CSR_CENTER_Y = 2'd1;
   localparam logic [CIDX_W-1:0] CSR_RADIUS   = 2'd2;

   typedef enum logic [1:0] {
      ED_NONE,
      ED_WRITE,
      ED_DELETE,
      ED_INSERT
   } edit_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      edit_type         kind;
      logic [CNT_W-1:0] pos;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SQUARE,
      ST_TEST,
      ST_END
   } state_type;

endpackage

// File: rtl/core/psc_cell.sv
// ---------------------------------------------------------------------------
// psc_cell
// One storage cell of the point chain: loads, shifts down or shifts up.
// ---------------------------------------------------------------------------
module psc_cell
   import psc_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int CW    = 16
) (
   input  logic          clock,
   input  cell_ctl_type  ctl,
   input  logic [CW-1:0] new_x,
   input  logic [CW-1:0] new_y,
   input  logic [CW-1:0] prev_x,
   input  logic [CW-1:0] prev_y,
   input  logic [CW-1:0] next_x,
   input  logic [CW-1:0] next_y,
   output logic [CW-1:0] x,
   output logic [CW-1:0] y
);

   localparam logic [CNT_W-1:0] MY_POS = CNT_W'(INDEX);

   logic [CW-1:0] x_ff, x_in;
   logic [CW-1:0] y_ff, y_in;

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      case (ctl.kind)
         ED_WRITE: begin
            if (ctl.pos == MY_POS) begin
               x_in = new_x;
               y_in = new_y;
            end
         end
         ED_DELETE: begin
            if (MY_POS >= ctl.pos) begin
               x_in = next_x;
               y_in = next_y;
            end
         end
         ED_INSERT: begin
            if (MY_POS > ctl.pos) begin
               x_in = prev_x;
               y_in = prev_y;
            end else if (MY_POS == ctl.pos) begin
               x_in = new_x;
               y_in = new_y;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
   end

   assign x = x_ff;
   assign y = y_ff;

endmodule

// File: rtl/core/psc_circle.sv
// ---------------------------------------------------------------------------
// psc_circle
// Two-stage circle membership test: |d| per axis, then squares and compare.
// ---------------------------------------------------------------------------
module psc_circle
   import psc_pkg::*;
#(
   parameter int CW = 16
) (
   input  logic             clock,
   input  logic             load_dist,
   input  logic             load_sq,
   input  logic [CW-1:0]    pt_x,
   input  logic [CW-1:0]    pt_y,
   input  logic [CW-1:0]    center_x,
   input  logic [CW-1:0]    center_y,
   input  logic [RAD_W-1:0] radius,
   output logic             hit
);

   localparam int DIST_W = (CW + 1 > RAD_W) ? CW + 1 : RAD_W;
   localparam int SQ_W   = 2 * RAD_W;

   logic [CW:0]     dx, dy;
   logic [CW:0]     adx_ff, adx_in;
   logic [CW:0]     ady_ff, ady_in;
   logic [DIST_W-1:0] adx_w, ady_w, rad_w;
   logic [RAD_W-1:0]  ax, ay;
   logic            near_ff, near_in;
   logic [SQ_W-1:0] sqx_ff, sqx_in;
   logic [SQ_W-1:0] sqy_ff, sqy_in;
   logic [SQ_W-1:0] rsq_ff, rsq_in;
   logic [SQ_W:0]   sum;

   // sign-extended differences never overflow at CW+1 bits
   assign dx = {pt_x[CW-1], pt_x} - {center_x[CW-1], center_x};
   assign dy = {pt_y[CW-1], pt_y} - {center_y[CW-1], center_y};
   assign adx_in = dx[CW] ? (~dx + 1'b1) : dx;
   assign ady_in = dy[CW] ? (~dy + 1'b1) : dy;

   assign adx_w = DIST_W'(adx_ff);
   assign ady_w = DIST_W'(ady_ff);
   assign rad_w = DIST_W'(radius);
   assign ax    = adx_w[RAD_W-1:0];
   assign ay    = ady_w[RAD_W-1:0];

   // when near, both magnitudes fit the radius width, so squares are exact
   assign near_in = (adx_w <= rad_w) && (ady_w <= rad_w);
   assign sqx_in  = ax * ax;
   assign sqy_in  = ay * ay;
   assign rsq_in  = radius * radius;

   assign sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign hit = near_ff && (sum <= {1'b0, rsq_ff});

   always_ff @(posedge clock) begin
      rsq_ff <= rsq_in;
      if (load_dist) begin
         adx_ff <= adx_in;
         ady_ff <= ady_in;
      end
      if (load_sq) begin
         near_ff <= near_in;
         sqx_ff  <= sqx_in;
         sqy_ff  <= sqy_in;
      end
   end

endmodule

// File: rtl/core/point_sequence_with_circle_scan.sv
// ---------------------------------------------------------------------------
// point_sequence_with_circle_scan
// Ordered store of up to DEPTH signed Q8.8 points with edit and circle scan.
// ---------------------------------------------------------------------------
// Usage:
//  - req_* channel carries one command request (cmd, slot, point_x/y);
//    taken when req_valid is high and req_stall is low.
//  - rsp_* channel returns results from an output register; taken when
//    rsp_valid is high and rsp_stall is low. A stalled result holds.
//  - csr_* writes center_x (0), center_y (1), radius (2); write only
//    while the block is idle.
//  - Append, read, modify, delete, insert, clear: one result, registered in
//    the cycle after the request; a new request is taken every cycle while the
//    result register drains. Delete and insert shift the cells from the slot up at once.
//  - Scan: one result per point inside the circle, then an end marker.
//    Each stored point passes the fetch (|d|), square and test (compare)
//    states through the one shared distance unit; no request is taken meanwhile.
//  - Receiver stall freezes the result register and holds off scan hits,
//    the end marker and new requests until that register frees up.
//  - Reset empties the store and clears the three registers to zero; the
//    cell contents are not cleared (never read at or above the fill count).
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module point_sequence_with_circle_scan
   import psc_pkg::*;
#(
   parameter int DEPTH      = 32,
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [CMD_W-1:0]             req_cmd,
   input  logic [SLOT_W-1:0]            req_slot,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_y,
   // result channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_accepted,
   output logic                         rsp_carries_point,
   output logic signed [COORD_BITS-1:0] rsp_out_x,
   output logic signed [COORD_BITS-1:0] rsp_out_y,
   output logic [CNT_W-1:0]             rsp_used_count,
   output logic                         rsp_last,
   // config port
   input  logic                         csr_write,
   input  logic [CIDX_W-1:0]            csr_index,
   input  logic [CSR_W-1:0]             csr_wdata
);

   localparam int CW    = COORD_BITS;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

   // config registers
   logic [CSR_W-1:0] center_x_ff, center_x_in;
   logic [CSR_W-1:0] center_y_ff, center_y_in;
   logic [RAD_W-1:0] radius_ff, radius_in;

   // control
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] scan_idx_ff, scan_idx_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_acc_ff, rsp_acc_in;
   logic             rsp_pt_ff, rsp_pt_in;
   logic [CW-1:0]    rsp_x_ff, rsp_x_in;
   logic [CW-1:0]    rsp_y_ff, rsp_y_in;
   logic [CNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic             rsp_last_ff, rsp_last_in;

   // scan point held for the result
   logic [CW-1:0]    pt_x_ff, pt_y_ff;

   logic             out_free;
   logic             req_take;
   logic             in_range;
   logic             not_full;
   logic             load_rsp;
   logic             load_dist;
   logic             load_sq;
   logic             circle_inside;
   logic [CNT_W-1:0] slot_pos;
   logic [IDX_W+SLOT_W-1:0] slot_wide;
   logic [IDX_W-1:0] rd_idx;
   logic [CW-1:0]    rd_x, rd_y;
   logic [CW+CSR_W-1:0] cx_wide, cy_wide;
   cell_ctl_type     cell_ctl;

   logic [CW-1:0]    cell_x [DEPTH];
   logic [CW-1:0]    cell_y [DEPTH];

   // -------------------------------------------------------------------
   // handshake
   // -------------------------------------------------------------------
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign req_take  = req_valid && !req_stall;

   assign slot_pos  = CNT_W'(req_slot);
   assign slot_wide = (IDX_W + SLOT_W)'(req_slot);
   assign in_range  = slot_pos < count_ff;   // count never exceeds DEPTH
   assign not_full  = count_ff < FULL;

   // single read port into the chain: slot while idle, scan index otherwise
   assign rd_idx = (state_ff == ST_IDLE) ? slot_wide[IDX_W-1:0] : scan_idx_ff[IDX_W-1:0];
   assign rd_x   = cell_x[rd_idx];
   assign rd_y   = cell_y[rd_idx];

   // center registers are 16 bits; fit them to the coordinate width
   assign cx_wide = (CW + CSR_W)'(center_x_ff);
   assign cy_wide = (CW + CSR_W)'(center_y_ff);

   // -------------------------------------------------------------------
   // cell chain
   // -------------------------------------------------------------------
   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic [CW-1:0] prev_x, prev_y, next_x, next_y;
      if (k == 0) begin : g_first
         assign prev_x = req_point_x;
         assign prev_y = req_point_y;
      end else begin : g_mid_prev
         assign prev_x = cell_x[k-1];
         assign prev_y = cell_y[k-1];
      end
      if (k == DEPTH - 1) begin : g_tail
         assign next_x = req_point_x;
         assign next_y = req_point_y;
      end else begin : g_mid_next
         assign next_x = cell_x[k+1];
         assign next_y = cell_y[k+1];
      end
      psc_cell #(
         .INDEX (k),
         .CW    (CW)
      ) u_cell (
         .clock  (clock),
         .ctl    (cell_ctl),
         .new_x  (req_point_x),
         .new_y  (req_point_y),
         .prev_x (prev_x),
         .prev_y (prev_y),
         .next_x (next_x),
         .next_y (next_y),
         .x      (cell_x[k]),
         .y      (cell_y[k])
      );
   end

   // -------------------------------------------------------------------
   // distance test
   // -------------------------------------------------------------------
   psc_circle #(
      .CW (CW)
   ) u_circle (
      .clock     (clock),
      .load_dist (load_dist),
      .load_sq   (load_sq),
      .pt_x      (rd_x),
      .pt_y      (rd_y),
      .center_x  (cx_wide[CW-1:0]),
      .center_y  (cy_wide[CW-1:0]),
      .radius    (radius_ff),
      .hit       (circle_inside)
   );

   // -------------------------------------------------------------------
   // next state
   // -------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_cmd == CMD_SCAN)) state_in = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = (scan_idx_ff < count_ff) ? ST_SQUARE : ST_END;
         end
         ST_SQUARE: state_in = ST_TEST;
         ST_TEST: begin
            if (!circle_inside || out_free) state_in = ST_FETCH;
         end
         ST_END: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // -------------------------------------------------------------------
   // datapath control and result composition
   // -------------------------------------------------------------------
   always_comb begin
      cell_ctl.kind = ED_NONE;
      cell_ctl.pos  = count_ff;
      count_in      = count_ff;
      scan_idx_in   = scan_idx_ff;
      load_dist     = 1'b0;
      load_sq       = 1'b0;
      load_rsp      = 1'b0;
      rsp_acc_in    = 1'b0;
      rsp_pt_in     = 1'b0;
      rsp_x_in      = '0;
      rsp_y_in      = '0;
      rsp_last_in   = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               load_rsp = (req_cmd != CMD_SCAN);
               case (req_cmd)
                  CMD_APPEND: begin
                     if (not_full) begin
                        cell_ctl.kind = ED_WRITE;
                        count_in      = count_ff + 1'b1;
                        rsp_acc_in    = 1'b1;
                     end
                  end
                  CMD_READ: begin
                     rsp_acc_in = in_range;
                     rsp_pt_in  = in_range;
                     if (in_range) begin
                        rsp_x_in = rd_x;
                        rsp_y_in = rd_y;
                     end
                  end
                  CMD_MODIFY: begin
                     if (in_range) begin
                        cell_ctl.kind = ED_WRITE;
                        cell_ctl.pos  = slot_pos;
                        rsp_acc_in    = 1'b1;
                     end
                  end
                  CMD_DELETE: begin
                     if (in_range) begin
                        cell_ctl.kind = ED_DELETE;
                        cell_ctl.pos  = slot_pos;
                        count_in      = count_ff - 1'b1;
                        rsp_acc_in    = 1'b1;
                     end
                  end
                  CMD_INSERT: begin
                     if (in_range && not_full) begin
                        cell_ctl.kind = ED_INSERT;
                        cell_ctl.pos  = slot_pos;
                        count_in      = count_ff + 1'b1;
                        rsp_acc_in    = 1'b1;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in   = '0;
                     rsp_acc_in = 1'b1;
                  end
                  CMD_SCAN: begin
                     scan_idx_in = '0;
                  end
                  default: begin
                     // unused code: refused
                  end
               endcase
            end
         end
         ST_FETCH: begin
            load_dist = 1'b1;
         end
         ST_SQUARE: begin
            load_sq = 1'b1;
         end
         ST_TEST: begin
            rsp_acc_in  = 1'b1;
            rsp_pt_in   = 1'b1;
            rsp_x_in    = pt_x_ff;
            rsp_y_in    = pt_y_ff;
            rsp_last_in = 1'b0;
            if (!circle_inside) begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end else if (out_free) begin
               load_rsp    = 1'b1;
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         ST_END: begin
            rsp_acc_in = 1'b1;
            load_rsp   = out_free;
         end
         default: begin
         end
      endcase

      rsp_cnt_in   = count_in;
      rsp_valid_in = load_rsp | (rsp_valid_ff & rsp_stall);
   end

   // config writes
   always_comb begin
      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      radius_in   = radius_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_CENTER_X: center_x_in = csr_wdata;
            CSR_CENTER_Y: center_y_in = csr_wdata;
            CSR_RADIUS:   radius_in   = csr_wdata[RAD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // -------------------------------------------------------------------
   // registers
   // -------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         scan_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         center_x_ff  <= '0;
         center_y_ff  <= '0;
         radius_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_idx_ff  <= scan_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         center_x_ff  <= center_x_in;
         center_y_ff  <= center_y_in;
         radius_ff    <= radius_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_acc_ff  <= rsp_acc_in;
         rsp_pt_ff   <= rsp_pt_in;
         rsp_x_ff    <= rsp_x_in;
         rsp_y_ff    <= rsp_y_in;
         rsp_cnt_ff  <= rsp_cnt_in;
         rsp_last_ff <= rsp_last_in;
      end
      if (load_dist) begin
         pt_x_ff <= rd_x;
         pt_y_ff <= rd_y;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_acc_ff;
   assign rsp_carries_point = rsp_pt_ff;
   assign rsp_out_x         = rsp_x_ff;
   assign rsp_out_y         = rsp_y_ff;
   assign rsp_used_count    = rsp_cnt_ff;
   assign rsp_last          = rsp_last_ff;

   // -------------------------------------------------------------------
   // assertions
   // -------------------------------------------------------------------
   `ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= FULL)
   `ASSERT_NEXT(a_scan_start, clock, reset, req_take && (req_cmd == CMD_SCAN),
                (state_ff == ST_FETCH) && (scan_idx_ff == '0))
   `ASSERT_NEXT(a_scan_hit, clock, reset,
                (state_ff == ST_TEST) && circle_inside && out_free,
                rsp_valid_ff && rsp_carries_point && !rsp_last_ff)
   `ASSERT_NEXT(a_scan_end, clock, reset, (state_ff == ST_END) && out_free,
                rsp_valid_ff && rsp_last_ff && (state_ff == ST_IDLE))

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point store with circle scan: self-checking testbench
// Requests (append, read, modify, delete, insert, clear, scan and the unused
// command code) are queued and driven in random bursts. Every accepted
// request runs through a local copy of the store that predicts the results.
// Results are drained under a shifting stall pattern and checked field by
// field in order. The circle registers are rewritten between phases while
// the block is idle.
// ----------------------------------------------------------------------------
module testbench;
   import psc_pkg::*;

   localparam int DEPTH         = 32;
   localparam int COORD_W       = 16;
   localparam int SETTLE_CYCLES = 4;     // quiet cycles before a register write
   localparam int QUIET_LIMIT   = 3000;  // cycles with no handshake before giving up

   // the block refuses this code; the package leaves it unnamed
   localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

   typedef struct {
      logic [CMD_W-1:0]          cmd;
      logic [SLOT_W-1:0]         slot;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } point_req_type;

   typedef struct {
      logic                      accepted;
      logic                      carries_point;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [CNT_W-1:0]          used_count;
      logic                      last;
   } point_rsp_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_HEAVY,
      STALL_LIGHT
   } stall_mode_type;

   // ---------------------------------------------------------------- DUT I/O
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [CMD_W-1:0]          req_cmd = CMD_APPEND;
   logic [SLOT_W-1:0]         req_slot = '0;
   logic signed [COORD_W-1:0] req_point_x = '0;
   logic signed [COORD_W-1:0] req_point_y = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_accepted;
   logic                      rsp_carries_point;
   logic signed [COORD_W-1:0] rsp_out_x;
   logic signed [COORD_W-1:0] rsp_out_y;
   logic [CNT_W-1:0]          rsp_used_count;
   logic                      rsp_last;
   logic                      csr_write = 1'b0;
   logic [CIDX_W-1:0]         csr_index = CSR_CENTER_X;
   logic [CSR_W-1:0]          csr_wdata = '0;

   point_sequence_with_circle_scan #(
      .DEPTH      (DEPTH),
      .COORD_BITS (COORD_W)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_slot          (req_slot),
      .req_point_x       (req_point_x),
      .req_point_y       (req_point_y),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_accepted      (rsp_accepted),
      .rsp_carries_point (rsp_carries_point),
      .rsp_out_x         (rsp_out_x),
      .rsp_out_y         (rsp_out_y),
      .rsp_used_count    (rsp_used_count),
      .rsp_last          (rsp_last),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------- predicted store
   // Local copy of the store and the circle registers, advanced once per
   // accepted request. Entries above the count are never read.
   logic signed [COORD_W-1:0] stored_x [DEPTH];
   logic signed [COORD_W-1:0] stored_y [DEPTH];
   int                        stored_count = 0;
   logic signed [COORD_W-1:0] circle_cx = '0;
   logic signed [COORD_W-1:0] circle_cy = '0;
   logic [RAD_W-1:0]          circle_r = '0;

   point_req_type pending_reqs [$];   // requests not yet driven
   point_rsp_type expected_rsps [$];  // results owed by the block, oldest first

   int  mismatch_count = 0;
   int  reqs_taken = 0;
   int  rsps_checked = 0;
   int  scan_hits = 0;
   int  circle_settings = 0;
   int  queued_total = 0;
   int  plan_count = 0;            // count as the generator expects it
   bit  req_taken = 1'b0;          // request accepted at the last rising edge

   function automatic void post_result(bit acc, bit has_pt,
                                       logic signed [COORD_W-1:0] x,
                                       logic signed [COORD_W-1:0] y, bit fin);
      point_rsp_type r;
      r.accepted      = acc;
      r.carries_point = has_pt;
      r.x             = has_pt ? x : '0;
      r.y             = has_pt ? y : '0;
      r.used_count    = stored_count[CNT_W-1:0];
      r.last          = fin;
      expected_rsps.push_back(r);
   endfunction

   // inclusive circle test, exact in 64 bits; far points rejected per axis
   function automatic bit in_circle(logic signed [COORD_W-1:0] x,
                                    logic signed [COORD_W-1:0] y);
      longint dx, dy, r;
      dx = longint'(x) - longint'(circle_cx);
      dy = longint'(y) - longint'(circle_cy);
      r  = longint'(circle_r);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      if (dx > r || dy > r) return 1'b0;
      return (dx * dx + dy * dy) <= (r * r);
   endfunction

   function automatic void apply_command(point_req_type rq);
      bit in_range;
      int k;
      in_range = int'(rq.slot) < stored_count;
      case (rq.cmd)
         CMD_APPEND: begin
            if (stored_count < DEPTH) begin
               stored_x[stored_count] = rq.x;
               stored_y[stored_count] = rq.y;
               stored_count++;
               post_result(1'b1, 1'b0, '0, '0, 1'b1);
            end else begin
               post_result(1'b0, 1'b0, '0, '0, 1'b1);
            end
         end
         CMD_READ: begin
            if (in_range)
               post_result(1'b1, 1'b1, stored_x[rq.slot], stored_y[rq.slot], 1'b1);
            else
               post_result(1'b0, 1'b0, '0, '0, 1'b1);
         end
         CMD_MODIFY: begin
            if (in_range) begin
               stored_x[rq.slot] = rq.x;
               stored_y[rq.slot] = rq.y;
            end
            post_result(in_range, 1'b0, '0, '0, 1'b1);
         end
         CMD_DELETE: begin
            if (in_range) begin
               for (k = rq.slot; k + 1 < stored_count; k++) begin
                  stored_x[k] = stored_x[k+1];
                  stored_y[k] = stored_y[k+1];
               end
               stored_count--;
            end
            post_result(in_range, 1'b0, '0, '0, 1'b1);
         end
         CMD_INSERT: begin
            // only below the count, so never into an empty store
            if (in_range && stored_count < DEPTH) begin
               for (k = stored_count; k > rq.slot; k--) begin
                  stored_x[k] = stored_x[k-1];
                  stored_y[k] = stored_y[k-1];
               end
               stored_x[rq.slot] = rq.x;
               stored_y[rq.slot] = rq.y;
               stored_count++;
               post_result(1'b1, 1'b0, '0, '0, 1'b1);
            end else begin
               post_result(1'b0, 1'b0, '0, '0, 1'b1);
            end
         end
         CMD_CLEAR: begin
            stored_count = 0;
            post_result(1'b1, 1'b0, '0, '0, 1'b1);
         end
         CMD_SCAN: begin
            // hits in storage order, then the end marker
            for (k = 0; k < stored_count; k++) begin
               if (in_circle(stored_x[k], stored_y[k])) begin
                  post_result(1'b1, 1'b1, stored_x[k], stored_y[k], 1'b0);
                  scan_hits++;
               end
            end
            post_result(1'b1, 1'b0, '0, '0, 1'b1);
         end
         default: post_result(1'b0, 1'b0, '0, '0, 1'b1);
      endcase
   endfunction

   task automatic check_field(string name, logic signed [31:0] want,
                              logic signed [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // ------------------------------------------------------------- monitors
   // Both channels are sampled at the rising edge; the request is run
   // through the local store first, then any result is checked.
   always @(posedge clock) begin
      point_req_type rq;
      point_rsp_type want;
      req_taken = 1'b0;
      if (!reset && req_valid && !req_stall) begin
         rq.cmd  = req_cmd;
         rq.slot = req_slot;
         rq.x    = req_point_x;
         rq.y    = req_point_y;
         apply_command(rq);
         req_taken = 1'b1;
         reqs_taken++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $error("result arrived with nothing outstanding");
            mismatch_count++;
         end else begin
            want = expected_rsps.pop_front();
            check_field("accepted", want.accepted, rsp_accepted);
            check_field("carries_point", want.carries_point, rsp_carries_point);
            check_field("out_x", want.x, rsp_out_x);
            check_field("out_y", want.y, rsp_out_y);
            check_field("used_count", want.used_count, rsp_used_count);
            check_field("last", want.last, rsp_last);
            rsps_checked++;
         end
      end
   end

   // watchdog: no handshake on either channel for too long ends the run
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // --------------------------------------------------------------- driver
   // Bursts of random length with random gaps; a third of the gaps are empty
   // so bursts run back to back. A stalled request holds its payload.
   int burst_left = 1;
   int gap_left = 0;
   always @(negedge clock) begin
      point_req_type nxt;
      logic          drive;
      drive = req_valid;
      if (!req_valid || req_taken) begin
         drive = 1'b0;
         if (reset) begin
            // nothing goes out during reset
         end else if (gap_left > 0) begin
            gap_left--;
         end else if (pending_reqs.size() > 0) begin
            nxt = pending_reqs.pop_front();
            req_cmd     <= nxt.cmd;
            req_slot    <= nxt.slot;
            req_point_x <= nxt.x;
            req_point_y <= nxt.y;
            drive = 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
      req_valid <= drive;
   end

   // result stall: the pattern (none, random, heavy, light) is picked anew at random
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left = 0;
   int             stall_period = 2;
   int unsigned    stall_tick = 0;
   always @(negedge clock) begin
      logic hold;
      if (mode_left == 0) begin
         stall_mode   = stall_mode_type'($urandom_range(0, 3));
         mode_left    = $urandom_range(8, 64);
         stall_period = $urandom_range(2, 8);
      end
      mode_left--;
      stall_tick++;
      case (stall_mode)
         STALL_NONE:   hold = 1'b0;
         STALL_RANDOM: hold = ($urandom_range(0, 2) == 0);
         STALL_HEAVY:  hold = (stall_tick % stall_period) != 0;
         default:      hold = (stall_tick % stall_period) == 0;
      endcase
      rsp_stall <= hold;
   end

   // ------------------------------------------------------------ generator
   function automatic void queue_request(logic [CMD_W-1:0] cmd, int slot,
                                         logic signed [COORD_W-1:0] x,
                                         logic signed [COORD_W-1:0] y);
      point_req_type rq;
      rq.cmd  = cmd;
      rq.slot = slot[SLOT_W-1:0];
      rq.x    = x;
      rq.y    = y;
      pending_reqs.push_back(rq);
      queued_total++;
      // track only the count so slots can be aimed in range
      case (cmd)
         CMD_APPEND: if (plan_count < DEPTH) plan_count++;
         CMD_DELETE: if (slot < plan_count) plan_count--;
         CMD_INSERT: if (slot < plan_count && plan_count < DEPTH) plan_count++;
         CMD_CLEAR:  plan_count = 0;
         default: ;
      endcase
   endfunction

   // coordinate around a center, a little past the radius now and then
   function automatic logic signed [COORD_W-1:0] near_coord(
         logic signed [COORD_W-1:0] c, int unsigned r);
      longint v;
      longint off;
      off = longint'($urandom_range(0, r + r / 4));
      v = ($urandom_range(0, 1) == 1) ? longint'(c) + off : longint'(c) - off;
      if (v > 32767)  v = 32767;
      if (v < -32768) v = -32768;
      return v[COORD_W-1:0];
   endfunction

   function automatic void pick_point(output logic signed [COORD_W-1:0] x,
                                      output logic signed [COORD_W-1:0] y);
      if ($urandom_range(0, 99) < 65) begin
         x = near_coord(circle_cx, circle_r);
         y = near_coord(circle_cy, circle_r);
      end else begin
         x = COORD_W'($urandom);
         y = COORD_W'($urandom);
      end
   endfunction

   // mostly in range; a fifth of the time at or past the count
   function automatic int pick_slot();
      if (plan_count > 0 && ($urandom_range(0, 4) != 0 || plan_count >= DEPTH))
         return $urandom_range(0, plan_count - 1);
      return $urandom_range(plan_count, DEPTH - 1);
   endfunction

   function automatic void queue_mix(int n);
      int goal;
      int pick;
      int run;
      logic signed [COORD_W-1:0] x, y;
      goal = queued_total + n;
      while (queued_total < goal) begin
         pick = $urandom_range(0, 99);
         pick_point(x, y);
         if (pick < 35) begin
            queue_request(CMD_APPEND, $urandom_range(0, DEPTH - 1), x, y);
         end else if (pick < 45) begin
            queue_request(CMD_INSERT, pick_slot(), x, y);
         end else if (pick < 55) begin
            queue_request(CMD_READ, pick_slot(), x, y);
         end else if (pick < 63) begin
            queue_request(CMD_MODIFY, pick_slot(), x, y);
         end else if (pick < 73) begin
            queue_request(CMD_DELETE, pick_slot(), x, y);
         end else if (pick < 85) begin
            // slot and point are ignored by a scan; random bits go out anyway
            queue_request(CMD_SCAN, $urandom_range(0, DEPTH - 1), x, y);
         end else if (pick < 88) begin
            queue_request(CMD_CLEAR, $urandom_range(0, DEPTH - 1), x, y);
         end else if (pick < 90) begin
            queue_request(CMD_UNUSED, $urandom_range(0, DEPTH - 1), x, y);
         end else begin
            // run of appends to build up content
            run = $urandom_range(4, 12);
            repeat (run) begin
               pick_point(x, y);
               queue_request(CMD_APPEND, $urandom_range(0, DEPTH - 1), x, y);
            end
         end
      end
   endfunction

   task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_CENTER_X: circle_cx = data;
         CSR_CENTER_Y: circle_cy = data;
         CSR_RADIUS:   circle_r  = data[RAD_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_circle(logic signed [COORD_W-1:0] cx,
                             logic signed [COORD_W-1:0] cy, logic [RAD_W-1:0] r);
      write_reg(CSR_CENTER_X, cx);
      write_reg(CSR_CENTER_Y, cy);
      write_reg(CSR_RADIUS, {1'b0, r});
      @(negedge clock);
      csr_write <= 1'b0;
      circle_settings++;
      // queue filling happens away from the driver's edge
      @(posedge clock);
   endtask

   // Sender idle (checked at the rising edge, where the queue and valid are
   // steady), then every result in (checked at the falling edge, where the
   // result queue is steady), then a quiet settling wait.
   task automatic wait_drained();
      bit done;
      done = 1'b0;
      while (!done) begin
         @(posedge clock);
         if (pending_reqs.size() == 0 && !req_valid) begin
            @(negedge clock);
            done = (expected_rsps.size() == 0);
         end
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // ------------------------------------------------------------- sequence
   initial begin
      logic signed [COORD_W-1:0] x, y;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(posedge clock);

      // Directed, with the registers at their reset values (circle of
      // radius zero at the origin). Refusals on the empty store first.
      circle_settings++;
      queue_request(CMD_SCAN,   0, '0, '0);     // empty: end marker only
      queue_request(CMD_READ,   0, '0, '0);
      queue_request(CMD_MODIFY, 0, 16'sh1234, 16'sh4321);
      queue_request(CMD_DELETE, 0, '0, '0);
      queue_request(CMD_INSERT, 0, 16'sh0100, 16'sh0100);  // empty: refused
      queue_request(CMD_UNUSED, 31, 16'shFFFF, 16'shFFFF);
      queue_request(CMD_APPEND, 0, -16'sd32768, -16'sd32768);
      queue_request(CMD_APPEND, 31, 16'sd32767, 16'sd32767);
      queue_request(CMD_APPEND, 0, '0, '0);
      queue_request(CMD_APPEND, 0, -16'sd1, -16'sd1);
      queue_request(CMD_READ,   1, '0, '0);
      queue_request(CMD_INSERT, 1, 16'sh5555, -16'sh5556);
      queue_request(CMD_MODIFY, 4, -16'sd256, 16'sd256);
      queue_request(CMD_READ,   4, '0, '0);
      queue_request(CMD_SCAN,   0, '0, '0);     // zero radius: only the origin
      queue_request(CMD_DELETE, 0, '0, '0);
      queue_request(CMD_READ,   4, '0, '0);     // one past the end now
      queue_request(CMD_CLEAR,  0, '0, '0);
      queue_request(CMD_READ,   0, '0, '0);
      wait_drained();

      // Boundary of a 500 circle: a 3-4-5 point sits exactly on it, one
      // step further is out; an axis offset of 501 fails the per-axis test.
      set_circle(16'sd1000, -16'sd1000, 15'd500);
      queue_request(CMD_APPEND, 0, 16'sd1300, -16'sd600);
      queue_request(CMD_APPEND, 0, 16'sd1300, -16'sd599);
      queue_request(CMD_APPEND, 0, 16'sd500, -16'sd1000);
      queue_request(CMD_APPEND, 0, 16'sd1501, -16'sd1000);
      queue_request(CMD_APPEND, 0, 16'sd1000, -16'sd1000);
      queue_request(CMD_SCAN, 0, '0, '0);
      wait_drained();

      // Largest circle: fill to capacity, then poke the full store.
      set_circle('0, '0, 15'h7FFF);
      while (plan_count < DEPTH) begin
         pick_point(x, y);
         queue_request(CMD_APPEND, 0, x, y);
      end
      pick_point(x, y);
      queue_request(CMD_APPEND, 0, x, y);              // full: refused
      queue_request(CMD_INSERT, 0, x, y);              // full: refused
      queue_request(CMD_READ, DEPTH - 1, '0, '0);
      queue_request(CMD_SCAN, 0, '0, '0);              // up to 32 hits
      queue_request(CMD_DELETE, DEPTH - 1, '0, '0);
      queue_request(CMD_INSERT, 0, x, y);
      queue_request(CMD_SCAN, 0, '0, '0);
      queue_mix(20);
      wait_drained();

      // Corner centers, largest and zero radius.
      set_circle(-16'sd32768, 16'sd32767, 15'h7FFF);
      queue_mix(45);
      wait_drained();
      set_circle(16'sd32767, -16'sd32768, 15'd0);
      queue_mix(40);
      wait_drained();

      // Random centers, moderate then any radius.
      set_circle(COORD_W'($urandom), COORD_W'($urandom),
                 RAD_W'($urandom_range(1, 4096)));
      queue_mix(45);
      wait_drained();
      set_circle(COORD_W'($urandom), COORD_W'($urandom),
                 RAD_W'($urandom_range(0, 32767)));
      queue_mix(40);
      wait_drained();

      $display("Run covered %0d requests and %0d results, %0d of them scan hits,",
               reqs_taken, rsps_checked, scan_hits);
      $display("under %0d circle settings.", circle_settings);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// File: point_sequence_with_circle_scan.f
+incdir+rtl/core
rtl/core/psc_pkg.sv
rtl/core/psc_cell.sv
rtl/core/psc_circle.sv
rtl/core/point_sequence_with_circle_scan.sv
verif/testbench.sv
